// ===== sv/xcrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the XMODEM-CRC receiver.
`timescale 1ns / 1ps

package xcrc_pkg;

	// Protocol characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_CAN = 8'h18;

	// Packet geometry: block number, complement, payload, two CRC bytes
	localparam int unsigned PAYLOAD_LEN = 128;
	localparam logic [7:0]  POS_BLOCK   = 8'd0;
	localparam logic [7:0]  POS_COMPL   = 8'd1;
	localparam logic [7:0]  POS_CRC_HI  = 8'(PAYLOAD_LEN + 2);

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Reply codes
	localparam logic REPLY_ACK = 1'b0;
	localparam logic REPLY_NAK = 1'b1;

	// Packet status codes
	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_GOOD = 2'd1,
		ST_BAD  = 2'd2,
		ST_END  = 2'd3
	} status_t;

	// What the front end decided a received byte is
	typedef enum logic [2:0] {
		CLS_IGNORE = 3'd0,
		CLS_SOH    = 3'd1,
		CLS_EOT    = 3'd2,
		CLS_CAN    = 3'd3,
		CLS_BLOCK  = 3'd4,
		CLS_COMPL  = 3'd5,
		CLS_DATA   = 3'd6,
		CLS_CRC_HI = 3'd7
	} cls_t;

	// One classified beat travelling from the front end to the back end.
	// The closing CRC byte is marked by last, with cls left as CLS_IGNORE.
	typedef struct packed {
		cls_t       cls;
		logic       last;
		logic [7:0] data;
		logic [6:0] index;
		logic       sink_ok;
	} item_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	// Byte-wide CRC-16-CCITT update, MSB first, no reflection
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== sv/xcrc_front.sv =====
// Front end: accepts received bytes, tracks packet framing and classifies each beat.
`timescale 1ns / 1ps

module xcrc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             sink_ok,
	input  logic             q_full,
	output logic             push,
	output xcrc_pkg::item_t  push_item
);

	logic       in_pkt_q;
	logic [7:0] pos_q;
	logic       accept;
	logic       close;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	// Classify the byte from its value while idle and from the framing position in a packet
	always_comb begin
		push_item         = '0;
		push_item.data    = rx_byte;
		push_item.sink_ok = sink_ok;
		push_item.index   = pos_q[6:0] - 7'd2;
		push_item.cls     = xcrc_pkg::CLS_IGNORE;
		push_item.last    = 1'b0;
		close             = 1'b0;
		if (!in_pkt_q) begin
			case (rx_byte)
				xcrc_pkg::CH_SOH: push_item.cls = xcrc_pkg::CLS_SOH;
				xcrc_pkg::CH_EOT: push_item.cls = xcrc_pkg::CLS_EOT;
				xcrc_pkg::CH_CAN: push_item.cls = xcrc_pkg::CLS_CAN;
				default:          push_item.cls = xcrc_pkg::CLS_IGNORE;
			endcase
		end else if (pos_q == xcrc_pkg::POS_BLOCK) begin
			push_item.cls = xcrc_pkg::CLS_BLOCK;
		end else if (pos_q == xcrc_pkg::POS_COMPL) begin
			push_item.cls = xcrc_pkg::CLS_COMPL;
		end else if (pos_q < xcrc_pkg::POS_CRC_HI) begin
			push_item.cls = xcrc_pkg::CLS_DATA;
		end else if (pos_q == xcrc_pkg::POS_CRC_HI) begin
			push_item.cls = xcrc_pkg::CLS_CRC_HI;
		end else begin
			push_item.last = 1'b1;
			close          = 1'b1;
		end
	end

	// Framing state: open on SOH, count bytes, close after the CRC low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
		end else if (accept) begin
			if (!in_pkt_q) begin
				if (rx_byte == xcrc_pkg::CH_SOH) begin
					in_pkt_q <= 1'b1;
					pos_q    <= '0;
				end
			end else if (close) begin
				in_pkt_q <= 1'b0;
				pos_q    <= '0;
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

// ===== sv/xcrc_queue.sv =====
// Two-entry queue of classified beats between the front and back ends.
`timescale 1ns / 1ps

module xcrc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xcrc_pkg::item_t   push_item,
	input  logic              pop,
	output logic              full,
	output xcrc_pkg::q_out_t  head
);

	xcrc_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/xcrc_back.sv =====
// Back end: header check, running CRC, reply decision and the output register.
`timescale 1ns / 1ps

module xcrc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  xcrc_pkg::q_out_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              reply_valid,
	output logic              reply_code,
	output logic              payload_valid,
	output logic [7:0]        payload_byte,
	output logic [6:0]        payload_index,
	output logic [1:0]        packet_status
);

	logic [7:0]  block_q;
	logic        hdr_ok_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;
	logic        out_valid_q;

	logic        rv_d;
	logic        rc_d;
	logic        pv_d;
	logic [7:0]  pb_d;
	logic [6:0]  pi_d;
	logic [1:0]  st_d;
	logic        good;
	logic        rv_q;
	logic        rc_q;
	logic        pv_q;
	logic [7:0]  pb_q;
	logic [6:0]  pi_q;
	logic [1:0]  st_q;

	// Take a beat when the output register is empty or being drained
	assign pop = head.valid && (!out_valid_q || !out_stall);

	assign good = hdr_ok_q && ({crc_hi_q, head.item.data} == crc_q) && head.item.sink_ok;

	// Result of the beat at the head of the queue
	always_comb begin
		rv_d = 1'b0;
		rc_d = xcrc_pkg::REPLY_ACK;
		pv_d = 1'b0;
		pb_d = '0;
		pi_d = '0;
		st_d = xcrc_pkg::ST_NONE;
		if (head.item.last) begin
			rv_d = 1'b1;
			rc_d = good ? xcrc_pkg::REPLY_ACK : xcrc_pkg::REPLY_NAK;
			st_d = good ? xcrc_pkg::ST_GOOD : xcrc_pkg::ST_BAD;
		end else begin
			case (head.item.cls)
				xcrc_pkg::CLS_EOT: begin
					rv_d = 1'b1;
					rc_d = head.item.sink_ok ? xcrc_pkg::REPLY_ACK : xcrc_pkg::REPLY_NAK;
					st_d = xcrc_pkg::ST_END;
				end
				xcrc_pkg::CLS_CAN: begin
					rv_d = 1'b1;
				end
				xcrc_pkg::CLS_DATA: begin
					pv_d = 1'b1;
					pb_d = head.item.data;
					pi_d = head.item.index;
				end
				default: begin
					rv_d = 1'b0;
				end
			endcase
		end
	end

	// Packet state kept by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q  <= '0;
			hdr_ok_q <= 1'b0;
			crc_q    <= '0;
			crc_hi_q <= '0;
		end else if (pop) begin
			case (head.item.cls)
				xcrc_pkg::CLS_SOH: begin
					hdr_ok_q <= 1'b0;
					crc_q    <= '0;
					crc_hi_q <= '0;
				end
				xcrc_pkg::CLS_BLOCK:  block_q  <= head.item.data;
				xcrc_pkg::CLS_COMPL:  hdr_ok_q <= (head.item.data == ~block_q);
				xcrc_pkg::CLS_DATA:   crc_q    <= xcrc_pkg::crc_byte(crc_q, head.item.data);
				xcrc_pkg::CLS_CRC_HI: crc_hi_q <= head.item.data;
				default:              crc_hi_q <= crc_hi_q;
			endcase
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			rv_q <= rv_d;
			rc_q <= rc_d;
			pv_q <= pv_d;
			pb_q <= pb_d;
			pi_q <= pi_d;
			st_q <= st_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_valid   = rv_q;
	assign reply_code    = rc_q;
	assign payload_valid = pv_q;
	assign payload_byte  = pb_q;
	assign payload_index = pi_q;
	assign packet_status = st_q;

endmodule

// ===== sv/xmodem_crc_packet_receiver.sv =====
// Top level of the XMODEM-CRC 128-byte packet receiver.
//
// Usage: received bytes enter on the input channel (in_valid, in_stall, rx_byte, sink_ok),
// one beat per byte. sink_ok is sampled with an EOT while idle and with the last CRC
// byte of a packet, and is ignored otherwise. Every input beat yields exactly one
// result beat on the output channel (out_valid, out_stall): a reply request with its
// ACK/NAK code, a tentative payload byte with its index, and a packet status.
// The front end tracks the packet framing and classifies each byte; a two-entry
// queue carries the classified beats to the back end, which keeps the header check
// and running CRC-16 and holds the result in an output register.
// An accepted beat is written into the queue and, when the output register is free,
// passes from there into the output register that drives out_valid.
// Throughput is one byte per cycle while out_stall is low, with the CRC updated bytewise.
// When the receiver stalls, the output register holds its beat, the queue fills,
// and in_stall rises once the queue holds two beats.
// Reset clears the framing state, the queue and the output valid flag; the block
// starts idle, waiting for SOH, EOT or CAN.
`timescale 1ns / 1ps

module xmodem_crc_packet_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       sink_ok,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reply_valid,
	output logic       reply_code,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic [6:0] payload_index,
	output logic [1:0] packet_status
);

	logic              q_full;
	logic              push;
	logic              pop;
	xcrc_pkg::item_t   push_item;
	xcrc_pkg::q_out_t  head;

	xcrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.sink_ok   (sink_ok),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	xcrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	xcrc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reply_valid   (reply_valid),
		.reply_code    (reply_code),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.packet_status (packet_status)
	);

	// A result beat never carries both a reply and a payload byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reply_valid && payload_valid))
		else $error("reply and payload in the same beat");

	// Payload fields are zero when no payload byte is carried
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !payload_valid) |-> (payload_byte == 8'd0 && payload_index == 7'd0))
		else $error("payload fields set without a payload byte");

	// A good packet always goes with an ACK reply
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && packet_status == xcrc_pkg::ST_GOOD) |->
			(reply_valid && reply_code == xcrc_pkg::REPLY_ACK))
		else $error("good packet without ACK");

	// An accepted byte reaches the output through the queue and output register if the output was free
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |-> ##2 out_valid)
		else $error("accepted byte did not reach the output");

endmodule
